// ===== design/ase_pkg.sv =====
`timescale 1ns / 1ps

package ase_pkg;

    localparam int ELAPSED_W      = 32;
    localparam int ESTIMATE_W     = 33;
    localparam int SAMPLE_COUNT_W = 24;
    localparam int CFG_W          = 32;
    localparam int PADDR_W        = 3;
    localparam int MEAN_W         = 32;
    localparam int SUM_W          = 64;
    localparam int ROOT_W         = 32;
    localparam int ALU_W          = 35;
    localparam int STEP_W         = 6;
    localparam int MEAN_STEPS     = 32;
    localparam int VAR_STEPS      = 64;
    localparam int SQRT_STEPS     = 32;

    localparam logic [CFG_W-1:0] ESTIMATE_RESET = 32'd1000000;

    localparam logic REQ_BEGIN  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic CFG_IDX_INIT_EST = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_DIV,
        S_MEAN_UPD,
        S_MULT,
        S_SUM,
        S_VAR_DIV,
        S_SQRT,
        S_FINISH,
        S_EMIT
    } t_state;

endpackage

// ===== design/ase_if.sv =====
`timescale 1ns / 1ps

interface ase_req_if
    import ase_pkg::*;
#(
    parameter int TARGET_BITS = 40
);
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [TARGET_BITS-1:0] target_ns;
    logic [ELAPSED_W-1:0]   elapsed_ns;

    modport source (output valid, req_type, target_ns, elapsed_ns, input ready);
    modport sink   (input valid, req_type, target_ns, elapsed_ns, output ready);
endinterface

interface ase_rsp_if
    import ase_pkg::*;
#(
    parameter int TARGET_BITS = 40
);
    logic                        valid;
    logic                        ready;
    logic                        keep_sleeping;
    logic signed [TARGET_BITS:0] remaining_ns;
    logic [ESTIMATE_W-1:0]       estimate_ns;
    logic [SAMPLE_COUNT_W-1:0]   sample_count;

    modport source (output valid, keep_sleeping, remaining_ns, estimate_ns, sample_count,
                    input ready);
    modport sink   (input valid, keep_sleeping, remaining_ns, estimate_ns, sample_count,
                    output ready);
endinterface

// ===== design/adaptive_sleep_estimator.sv =====
`timescale 1ns / 1ps
// Adaptive sleep estimator.
// Request channel i_in: a begin beat (req_type 0) loads target_ns as the remaining
// time, clears the statistics and reloads the estimate from initial_estimate_ns.
// A sample beat (req_type 1) subtracts elapsed_ns from the remaining time and
// updates the running mean, the sum of squared deviations and the estimate.
// Response channel o_out: exactly one beat per request, carrying keep_sleeping,
// remaining_ns, estimate_ns and sample_count after that request.
// The block works on one request at a time; i_in.ready is high only while idle.
// A begin beat goes straight to the output stage. The first sample of a session
// runs only the mean division; later samples add the variance division and the integer
// square root. One shared compare-subtract unit does 32 steps for the mean
// division, 64 for the variance division and 32 for the root, one step per cycle.
// The response sits in an output register; when the receiver stalls, the block
// holds it and finishes no further request until it is taken.
// The APB register initial_estimate_ns lives at address 0 and takes effect at
// the next begin beat. Synchronous reset clears the statistics, sets the
// estimate and the register to 1000000 and leaves no response pending.
module adaptive_sleep_estimator
    import ase_pkg::*;
#(
    parameter int TARGET_BITS = 40,
    parameter int COUNT_BITS  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ase_req_if.sink            i_in,
    ase_rsp_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    localparam int REM_W  = TARGET_BITS + 1;
    localparam int DIFF_W = ((REM_W > ELAPSED_W + 1) ? REM_W : ELAPSED_W + 1) + 1;
    localparam int CMP_W  = (REM_W > ESTIMATE_W + 1) ? REM_W : ESTIMATE_W + 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]          r_cfg;
    logic signed [REM_W-1:0]   r_rem, n_rem;
    logic [MEAN_W-1:0]         r_mean, n_mean;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [COUNT_BITS-1:0]     r_cnt, n_cnt;
    logic [ESTIMATE_W-1:0]     r_est, n_est;
    logic [ELAPSED_W-1:0]      r_x, n_x;
    logic                      r_dneg, n_dneg;
    logic [MEAN_W-1:0]         r_ad, n_ad;
    logic [MEAN_W-1:0]         r_aa, n_aa;
    logic [SUM_W-1:0]          r_prod, n_prod;
    logic [SUM_W-1:0]          r_acc, n_acc;
    logic [ALU_W-1:0]          r_prem, n_prem;
    logic [ROOT_W-1:0]         r_root, n_root;
    logic [STEP_W-1:0]         r_step, n_step;
    logic                      r_ovalid, n_ovalid;
    logic                      r_okeep, n_okeep;
    logic signed [REM_W-1:0]   r_orem, n_orem;
    logic [ESTIMATE_W-1:0]     r_oest, n_oest;
    logic [SAMPLE_COUNT_W-1:0] r_ocnt, n_ocnt;

    logic                      in_acc;
    logic                      out_free;
    logic                      cfg_wr;
    logic                      cnt_gt1;
    logic [COUNT_BITS-1:0]     cnt_m1;

    logic [ALU_W-1:0]          alu_a;
    logic [ALU_W-1:0]          alu_b;
    logic [ALU_W:0]            alu_diff;
    logic                      alu_ge;
    logic [ALU_W-1:0]          alu_rem;

    logic signed [DIFF_W-1:0]  rem_ext;
    logic signed [DIFF_W-1:0]  x_ext;
    logic signed [DIFF_W-1:0]  rem_sub;
    logic signed [DIFF_W-1:0]  rem_floor;
    logic [MEAN_W:0]           d_full;
    logic [MEAN_W:0]           d_abs;
    logic [MEAN_W-1:0]         quot;
    logic [MEAN_W-1:0]         mean_new;
    logic [MEAN_W:0]           after_full;
    logic [MEAN_W:0]           after_abs;
    logic [SUM_W-1:0]          prod;
    logic [SUM_W:0]            sum_add;
    logic [SUM_W-1:0]          sum_sat;
    logic signed [CMP_W-1:0]   rem_cmp;
    logic signed [CMP_W-1:0]   est_cmp;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_INIT_EST);
    assign cnt_gt1  = r_cnt > COUNT_BITS'(1);
    assign cnt_m1   = r_cnt - COUNT_BITS'(1);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_INIT_EST) ? r_cfg : '0;

    // Shared compare-subtract unit for both divisions and the square root.
    always_comb begin
        alu_a = {r_prem[ALU_W-2:0], r_acc[SUM_W-1]};
        alu_b = ALU_W'(r_cnt);
        if (r_state == S_SQRT) begin
            alu_a = {r_prem[ALU_W-3:0], r_acc[SUM_W-1 -: 2]};
            alu_b = ALU_W'({r_root, 2'b01});
        end else if (r_state == S_VAR_DIV) begin
            alu_b = ALU_W'(cnt_m1);
        end
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[ALU_W];
    assign alu_rem  = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;

    assign rem_ext   = DIFF_W'(r_rem);
    assign x_ext     = DIFF_W'($signed({1'b0, i_in.elapsed_ns}));
    assign rem_sub   = rem_ext - x_ext;
    assign rem_floor = {{(DIFF_W - TARGET_BITS){1'b1}}, {TARGET_BITS{1'b0}}};

    assign d_full = {1'b0, i_in.elapsed_ns} - {1'b0, r_mean};
    assign d_abs  = d_full[MEAN_W] ? (~d_full + 1'b1) : d_full;

    assign quot       = r_acc[MEAN_W-1:0];
    assign mean_new   = r_dneg ? (r_mean - quot) : (r_mean + quot);
    assign after_full = {1'b0, r_x} - {1'b0, mean_new};
    assign after_abs  = after_full[MEAN_W] ? (~after_full + 1'b1) : after_full;

    assign prod    = r_ad * r_aa;
    assign sum_add = {1'b0, r_sum} + {1'b0, r_prod};
    assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    assign rem_cmp = CMP_W'(r_rem);
    assign est_cmp = CMP_W'($signed({1'b0, r_est}));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.req_type == REQ_BEGIN) ? S_EMIT : S_MEAN_DIV;
                end
            end
            S_MEAN_DIV: begin
                if (r_step == STEP_W'(MEAN_STEPS - 1)) begin
                    n_state = S_MEAN_UPD;
                end
            end
            S_MEAN_UPD: n_state = S_MULT;
            S_MULT:     n_state = S_SUM;
            S_SUM:      n_state = cnt_gt1 ? S_VAR_DIV : S_FINISH;
            S_VAR_DIV: begin
                if (r_step == STEP_W'(VAR_STEPS - 1)) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH:   n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready          = (r_state == S_IDLE);
        o_out.valid         = r_ovalid;
        o_out.keep_sleeping = r_okeep;
        o_out.remaining_ns  = r_orem;
        o_out.estimate_ns   = r_oest;
        o_out.sample_count  = r_ocnt;
    end

    always_comb begin
        n_rem    = r_rem;
        n_mean   = r_mean;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_est    = r_est;
        n_x      = r_x;
        n_dneg   = r_dneg;
        n_ad     = r_ad;
        n_aa     = r_aa;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_prem   = r_prem;
        n_root   = r_root;
        n_step   = r_step;
        n_ovalid = r_ovalid && !o_out.ready;
        n_okeep  = r_okeep;
        n_orem   = r_orem;
        n_oest   = r_oest;
        n_ocnt   = r_ocnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.req_type == REQ_BEGIN) begin
                        n_rem  = REM_W'(i_in.target_ns);
                        n_mean = '0;
                        n_sum  = '0;
                        n_cnt  = '0;
                        n_est  = ESTIMATE_W'(r_cfg);
                    end else begin
                        n_rem  = (rem_sub < rem_floor) ? REM_W'(rem_floor) : REM_W'(rem_sub);
                        n_cnt  = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
                        n_x    = i_in.elapsed_ns;
                        n_dneg = d_full[MEAN_W];
                        n_ad   = d_abs[MEAN_W-1:0];
                        n_acc  = {d_abs[MEAN_W-1:0], {(SUM_W - MEAN_W){1'b0}}};
                        n_prem = '0;
                        n_step = '0;
                    end
                end
            end
            S_MEAN_DIV, S_VAR_DIV: begin
                n_prem = alu_rem;
                n_acc  = {r_acc[SUM_W-2:0], alu_ge};
                n_step = r_step + 1'b1;
                if (r_state == S_VAR_DIV && r_step == STEP_W'(VAR_STEPS - 1)) begin
                    n_prem = '0;
                    n_step = '0;
                end
            end
            S_MEAN_UPD: begin
                n_mean = mean_new;
                n_aa   = after_abs[MEAN_W-1:0];
            end
            S_MULT: begin
                n_prod = prod;
            end
            S_SUM: begin
                n_sum  = sum_sat;
                n_acc  = sum_sat;
                n_prem = '0;
                n_root = '0;
                n_step = '0;
            end
            S_SQRT: begin
                n_prem = alu_rem;
                n_acc  = {r_acc[SUM_W-3:0], 2'b00};
                n_root = {r_root[ROOT_W-2:0], alu_ge};
                n_step = r_step + 1'b1;
            end
            S_FINISH: begin
                n_est = {1'b0, r_mean} + {1'b0, r_root};
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okeep  = rem_cmp > est_cmp;
                    n_orem   = r_rem;
                    n_oest   = r_est;
                    n_ocnt   = SAMPLE_COUNT_W'(r_cnt);
                end
            end
            default: begin
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cfg    <= ESTIMATE_RESET;
            r_rem    <= '0;
            r_mean   <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_est    <= ESTIMATE_W'(ESTIMATE_RESET);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                r_cfg <= pwdata;
            end
            r_rem    <= n_rem;
            r_mean   <= n_mean;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_est    <= n_est;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_dneg  <= n_dneg;
        r_ad    <= n_ad;
        r_aa    <= n_aa;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_prem  <= n_prem;
        r_root  <= n_root;
        r_step  <= n_step;
        r_okeep <= n_okeep;
        r_orem  <= n_orem;
        r_oest  <= n_oest;
        r_ocnt  <= n_ocnt;
    end

endmodule

// ===== design/ase_checker.sv =====
`timescale 1ns / 1ps

module ase_checker #(
    parameter int TARGET_BITS = 40
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_req_type,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_keep,
    input logic signed [TARGET_BITS:0] i_out_rem,
    input logic [32:0]                 i_out_est,
    input logic [23:0]                 i_out_cnt
);

    // Types of the requests still owed a response, oldest first. One response may wait
    // in the output register while the next request is being worked on.
    logic [1:0] r_pend;
    logic       r_head_begin;
    logic       r_tail_begin;
    logic       in_acc;
    logic       out_acc;
    logic       keep_exp;

    assign in_acc   = i_in_valid && i_in_ready;
    assign out_acc  = i_out_valid && i_out_ready;
    assign keep_exp = i_out_rem > $signed({1'b0, i_out_est});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 2'd0;
            r_head_begin <= 1'b0;
            r_tail_begin <= 1'b0;
        end else begin
            unique case ({in_acc, out_acc})
                2'b10: begin
                    if (r_pend == 2'd0) begin
                        r_head_begin <= !i_in_req_type;
                    end else begin
                        r_tail_begin <= !i_in_req_type;
                    end
                    r_pend <= r_pend + 2'd1;
                end
                2'b01: begin
                    r_head_begin <= r_tail_begin;
                    r_pend       <= r_pend - 2'd1;
                end
                2'b11: begin
                    if (r_pend == 2'd1) begin
                        r_head_begin <= !i_in_req_type;
                    end else begin
                        r_head_begin <= r_tail_begin;
                        r_tail_begin <= !i_in_req_type;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("request accepted while a request was in progress");

    a_keep_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_keep == keep_exp))
        else $error("keep_sleeping disagrees with remaining and estimate");

    a_begin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && (r_pend != 2'd0) && r_head_begin) |-> (i_out_cnt == 24'd0))
        else $error("begin response carries a nonzero sample count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_rem)
                                          && $stable(i_out_est)))
        else $error("stalled response beat changed");

endmodule

bind adaptive_sleep_estimator ase_checker #(.TARGET_BITS(TARGET_BITS)) u_ase_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_req_type (i_in.req_type),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_keep    (o_out.keep_sleeping),
    .i_out_rem     (o_out.remaining_ns),
    .i_out_est     (o_out.estimate_ns),
    .i_out_cnt     (o_out.sample_count)
);

// ===== test/tb_adaptive_sleep_estimator.sv =====
`timescale 1ns / 1ps

module tb_adaptive_sleep_estimator;
    import ase_pkg::*;

    localparam int TARGET_BITS    = 40;
    localparam int COUNT_BITS     = 24;
    localparam int UNUSED_REG_IDX = 1;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 200;

    typedef longint unsigned t_u64;

    localparam longint REMAINING_FLOOR = -(longint'(1) <<< TARGET_BITS);
    localparam int unsigned SAMPLES_MAX = (1 << COUNT_BITS) - 1;
    localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX = '1;
    localparam logic [TARGET_BITS-1:0] TARGET_MAX  = '1;

    typedef struct {
        logic                      keep_sleeping;
        logic signed [TARGET_BITS:0] remaining_ns;
        logic [ESTIMATE_W-1:0]     estimate_ns;
        logic [SAMPLE_COUNT_W-1:0] sample_count;
    } t_sleep_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    ase_req_if #(.TARGET_BITS(TARGET_BITS)) req_bus ();
    ase_rsp_if #(.TARGET_BITS(TARGET_BITS)) rsp_bus ();

    adaptive_sleep_estimator #(
        .TARGET_BITS(TARGET_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_bus),
        .o_out  (rsp_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    t_sleep_result pending_results[$];
    int            errors;
    int            beats_sent;
    int            quiet_cycles;
    bit            steady_flow;

    logic [CFG_W-1:0] est_reg_copy;
    longint           remaining_left;
    longint           mean_ns;
    longint           estimate_now;
    t_u64             dev_sum;
    int unsigned      samples_seen_copy;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_u64 floor_root(t_u64 v);
        t_u64 root;
        t_u64 trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic t_sleep_result predict_sleep_result(logic typ,
                                                           logic [TARGET_BITS-1:0] tgt,
                                                           logic [ELAPSED_W-1:0] el);
        t_sleep_result r;
        longint        x;
        longint        d;
        longint        after;
        t_u64          prod;
        t_u64          spread;
        if (typ == REQ_BEGIN) begin
            remaining_left    = longint'(tgt);
            mean_ns           = 0;
            dev_sum           = 0;
            samples_seen_copy = 0;
            estimate_now      = longint'(est_reg_copy);
        end else begin
            x = longint'(el);
            remaining_left -= x;
            if (remaining_left < REMAINING_FLOOR) remaining_left = REMAINING_FLOOR;
            if (samples_seen_copy < SAMPLES_MAX) samples_seen_copy++;
            d = x - mean_ns;
            mean_ns += d / longint'(samples_seen_copy);
            after = x - mean_ns;
            prod = t_u64'(d < 0 ? -d : d) * t_u64'(after < 0 ? -after : after);
            if (dev_sum > ~64'd0 - prod) dev_sum = '1;
            else dev_sum += prod;
            // With a single sample there is no spread yet.
            spread = 0;
            if (samples_seen_copy > 1)
                spread = floor_root(dev_sum / t_u64'(samples_seen_copy - 1));
            estimate_now = mean_ns + longint'(spread);
        end
        r.keep_sleeping = remaining_left > estimate_now;
        r.remaining_ns  = remaining_left[TARGET_BITS:0];
        r.estimate_ns   = estimate_now[ESTIMATE_W-1:0];
        r.sample_count  = samples_seen_copy[SAMPLE_COUNT_W-1:0];
        return r;
    endfunction

    function automatic logic [TARGET_BITS-1:0] random_target();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TARGET_BITS-1:0] >> $urandom_range(0, TARGET_BITS - 1);
    endfunction

    function automatic logic [ELAPSED_W-1:0] jittered(logic [ELAPSED_W-1:0] base);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, base >> 3))
            - longint'($urandom_range(0, base >> 4));
        if (v > longint'(ELAPSED_MAX)) v = longint'(ELAPSED_MAX);
        return v[ELAPSED_W-1:0];
    endfunction

    task automatic send_beat(input logic typ, input logic [TARGET_BITS-1:0] tgt,
                             input logic [ELAPSED_W-1:0] el);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 20) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= typ;
        req_bus.target_ns  <= tgt;
        req_bus.elapsed_ns <= el;
        do @(posedge i_clk); while (!req_bus.ready);
        pending_results.push_back(predict_sleep_result(typ, tgt, el));
        beats_sent++;
    endtask

    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input int idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_IDX_INIT_EST) est_reg_copy = value;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        // A sample beat ahead of any begin works on the cleared state.
        send_beat(REQ_SAMPLE, '0, 32'd5);
        send_beat(REQ_BEGIN, '0, '0);
        wait_for_results();
    endtask

    task automatic test_estimate_register();
        write_register(CFG_IDX_INIT_EST, '0);
        send_beat(REQ_BEGIN, 40'd1, '0);
        send_beat(REQ_BEGIN, '0, '0);
        wait_for_results();
        write_register(CFG_IDX_INIT_EST, '1);
        send_beat(REQ_BEGIN, TARGET_MAX, '0);
        send_beat(REQ_BEGIN, 40'hFF_FFFF_FFFF >> 8, '0);
        wait_for_results();
        write_register(UNUSED_REG_IDX, 32'h1234_5678);
        send_beat(REQ_BEGIN, 40'd2_000_000, '0);
        wait_for_results();
        write_register(CFG_IDX_INIT_EST, ESTIMATE_RESET);
    endtask

    task automatic test_field_extremes();
        send_beat(REQ_BEGIN, TARGET_MAX, ELAPSED_MAX);
        // Alternating extreme samples drive the deviation sum into saturation.
        repeat (3) begin
            send_beat(REQ_SAMPLE, '0, '0);
            send_beat(REQ_SAMPLE, '0, ELAPSED_MAX);
        end
        send_beat(REQ_SAMPLE, TARGET_MAX, 32'd1);
        send_beat(REQ_BEGIN, 40'h55_5555_5555, 32'hAAAA_AAAA);
        send_beat(REQ_SAMPLE, 40'hAA_AAAA_AAAA, 32'hAAAA_AAAA);
        send_beat(REQ_SAMPLE, '0, 32'h5555_5555);
        send_beat(REQ_BEGIN, '0, '0);
        send_beat(REQ_SAMPLE, '0, '0);
    endtask

    task automatic test_steady_stream();
        logic [ELAPSED_W-1:0] base;
        steady_flow = 1'b1;
        base = $urandom_range(1000, 2_000_000);
        send_beat(REQ_BEGIN, random_target(), $urandom);
        repeat (40) send_beat(REQ_SAMPLE, random_target(), jittered(base));
        steady_flow = 1'b0;
    endtask

    task automatic test_remaining_underflow();
        wait_for_results();
        write_register(CFG_IDX_INIT_EST, $urandom);
        send_beat(REQ_BEGIN, 40'($urandom_range(0, 1_000_000)), '0);
        // Enough near-maximum sleeps to pin the remaining time at its floor.
        repeat (262)
            send_beat(REQ_SAMPLE, random_target(), ELAPSED_MAX - $urandom_range(0, 65535));
    endtask

    task automatic test_random_sessions();
        logic [ELAPSED_W-1:0] base;
        int                   n;
        while (beats_sent < 500) begin
            if ($urandom_range(3) == 0) begin
                wait_for_results();
                case ($urandom_range(4))
                    0: write_register(CFG_IDX_INIT_EST, '0);
                    1: write_register(CFG_IDX_INIT_EST, '1);
                    2: write_register(UNUSED_REG_IDX, $urandom);
                    default: write_register(CFG_IDX_INIT_EST, $urandom >> $urandom_range(0, 31));
                endcase
            end
            if ($urandom_range(9) != 0) send_beat(REQ_BEGIN, random_target(), $urandom);
            base = $urandom >> $urandom_range(0, 31);
            n = $urandom_range(1, 20);
            repeat (n) begin
                if ($urandom_range(9) == 0) send_beat(REQ_SAMPLE, random_target(), $urandom);
                else send_beat(REQ_SAMPLE, random_target(), jittered(base));
            end
        end
    endtask

    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        t_sleep_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, remaining_ns actual %0d",
                         $time, rsp_bus.remaining_ns);
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.keep_sleeping !== want.keep_sleeping) begin
                    errors++;
                    $display("%0t: keep_sleeping expected %0d actual %0d",
                             $time, want.keep_sleeping, rsp_bus.keep_sleeping);
                end
                if (rsp_bus.remaining_ns !== want.remaining_ns) begin
                    errors++;
                    $display("%0t: remaining_ns expected %0d actual %0d",
                             $time, want.remaining_ns, rsp_bus.remaining_ns);
                end
                if (rsp_bus.estimate_ns !== want.estimate_ns) begin
                    errors++;
                    $display("%0t: estimate_ns expected %0d actual %0d",
                             $time, want.estimate_ns, rsp_bus.estimate_ns);
                end
                if (rsp_bus.sample_count !== want.sample_count) begin
                    errors++;
                    $display("%0t: sample_count expected %0d actual %0d",
                             $time, want.sample_count, rsp_bus.sample_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_BEGIN;
        req_bus.target_ns  <= '0;
        req_bus.elapsed_ns <= '0;
        errors            = 0;
        beats_sent        = 0;
        steady_flow       = 1'b0;
        est_reg_copy      = ESTIMATE_RESET;
        remaining_left    = 0;
        mean_ns           = 0;
        dev_sum           = 0;
        samples_seen_copy = 0;
        estimate_now      = longint'(ESTIMATE_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_estimate_register();
        test_field_extremes();
        test_steady_stream();
        test_remaining_underflow();
        test_random_sessions();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
